// ----- src/ffxd_pkg.sv -----
// Shared types and codes for the form field extract and decode block.
package ffxd_pkg;

  localparam int COUNT_OUT_BITS = 12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_LOW      = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH     = 2'd1;
  localparam logic [1:0] CFG_KEY_LENGTH   = 2'd2;
  localparam logic [1:0] CFG_OUT_CAPACITY = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_NUL       = 2'd3;

  // Result word kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Everything one input byte produces, handed from the parser to the emitter.
  typedef struct packed {
    logic [1:0]                      n_data;
    logic [2:0][7:0]                 data;
    logic                            has_status;
    logic [7:0]                      status_byte;
    logic [1:0]                      code;
    logic [COUNT_OUT_BITS-1:0]       count;
  } bundle_t;

  typedef struct packed {
    logic                            kind;
    logic [7:0]                      out_byte;
    logic [1:0]                      code;
    logic [COUNT_OUT_BITS-1:0]       count;
    logic                            run_end;
  } result_t;

endpackage

// ----- src/ffxd_fifo.sv -----
// Small register queue with show-ahead read, used between the block's stages.
module ffxd_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/ffxd_front.sv -----
// Parser: config registers, key match, value decode; one byte per cycle unless stalled.
module ffxd_front #(
  parameter int MAX_KEY_BYTES = 16,
  parameter int COUNT_BITS    = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  output logic                bq_push,
  output ffxd_pkg::bundle_t   bq_data
);

  localparam int KP_W = $clog2(MAX_KEY_BYTES + 1);
  localparam int CW   = ((COUNT_BITS > 13) ? COUNT_BITS : 13) + 2;

  localparam logic [2:0] PH_KEY     = 3'd0;
  localparam logic [2:0] PH_SKIP    = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_ERR_OVF = 3'd4;
  localparam logic [2:0] PH_ERR_NUL = 3'd5;
  localparam logic [2:0] PH_IGNORE  = 3'd6;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  logic [63:0]           key_low_r, key_high_r;
  logic [4:0]            key_length_r;
  logic [12:0]           out_capacity_r;

  logic [2:0]            ph_r, ph_nxt;
  logic [KP_W-1:0]       kp_r, kp_nxt;
  logic [1:0]            pp_r, pp_nxt;
  logic [7:0]            fh_r, fh_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [7:0]            key_bytes [16];
  logic [KP_W-1:0]       klen;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_bytes[i]     = key_low_r[8*i +: 8];
      key_bytes[i + 8] = key_high_r[8*i +: 8];
    end
  end

  assign klen = (key_length_r > 5'(MAX_KEY_BYTES)) ? KP_W'(MAX_KEY_BYTES)
                                                     : KP_W'(key_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r      <= '0;
      key_high_r     <= '0;
      key_length_r   <= '0;
      out_capacity_r <= 13'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffxd_pkg::CFG_KEY_LOW:      key_low_r      <= cfg_data;
        ffxd_pkg::CFG_KEY_HIGH:     key_high_r     <= cfg_data;
        ffxd_pkg::CFG_KEY_LENGTH:   key_length_r   <= cfg_data[4:0];
        ffxd_pkg::CFG_OUT_CAPACITY: out_capacity_r <= cfg_data[12:0];
      endcase
    end
  end

  logic [2:0]            mid_ph, fin_ph;
  logic [KP_W-1:0]       mid_kp;
  logic [1:0]            mid_pp;
  logic [7:0]            mid_fh;
  logic [7:0]            cand [4];
  logic [1:0]            nc, na;
  logic                  ovf, has_st;
  logic [4:0]            hx, fhx;
  logic [7:0]            dec;
  logic [2:0]            room;
  logic [CW-1:0]         cntw, capw, cmaxw;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [1:0]            code;

  always_comb begin
    mid_ph  = ph_r;
    mid_kp  = kp_r;
    mid_pp  = pp_r;
    mid_fh  = fh_r;
    nc      = '0;
    has_st  = 1'b0;
    for (int i = 0; i < 4; i++) cand[i] = '0;
    hx  = hex_decode(text_byte);
    fhx = hex_decode(fh_r);
    dec = {fhx[3:0], hx[3:0]};

    if (ph_r != PH_IGNORE) begin
      if (text_byte == '0) begin
        has_st = 1'b1;
      end else begin
        unique case (ph_r)
          PH_KEY: begin
            if (text_byte == CH_AMP) begin
              mid_kp = '0;
            end else if (kp_r < klen) begin
              if (text_byte == key_bytes[4'(kp_r)]) mid_kp = kp_r + 1'b1;
              else mid_ph = PH_SKIP;
            end else if (text_byte == CH_EQUAL) begin
              mid_ph = (out_capacity_r == '0) ? PH_ERR_OVF : PH_VALUE;
              mid_kp = '0;
            end else begin
              mid_ph = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (text_byte == CH_AMP) begin
              mid_ph = PH_KEY;
              mid_kp = '0;
            end
          end
          PH_VALUE: begin
            // A percent with its digits either resolves here, or is given back
            // literally and this byte goes through the plain path.
            logic plain;
            plain = 1'b1;
            if (pp_r == 2'd1) begin
              if (hx[4]) begin
                mid_pp = 2'd2;
                mid_fh = text_byte;
                plain  = 1'b0;
              end else begin
                cand[nc] = CH_PERCENT; nc = nc + 1'b1;
                mid_pp   = 2'd0;
              end
            end else if (pp_r == 2'd2) begin
              if (hx[4]) begin
                mid_pp = 2'd0;
                mid_fh = '0;
                plain  = 1'b0;
                if (dec == '0) mid_ph = PH_ERR_NUL;
                else begin
                  cand[nc] = dec; nc = nc + 1'b1;
                end
              end else begin
                cand[nc] = CH_PERCENT; nc = nc + 1'b1;
                cand[nc] = fh_r;       nc = nc + 1'b1;
                mid_pp   = 2'd0;
              end
            end
            if (plain) begin
              if (text_byte == CH_AMP) mid_ph = PH_DONE;
              else if (text_byte == CH_PLUS) begin
                cand[nc] = CH_SPACE; nc = nc + 1'b1;
              end else if (text_byte == CH_PERCENT) mid_pp = 2'd1;
              else begin
                cand[nc] = text_byte; nc = nc + 1'b1;
              end
            end
          end
          default: ;
        endcase
        has_st = final_byte;
      end
      // Closing the body gives back any pending percent literally.
      if (has_st && mid_ph == PH_VALUE && mid_pp != 2'd0) begin
        cand[nc] = CH_PERCENT; nc = nc + 1'b1;
        if (mid_pp == 2'd2) begin
          cand[nc] = mid_fh; nc = nc + 1'b1;
        end
      end
    end
  end

  // Capacity check on each of up to three bytes written in this cycle.
  assign cntw  = CW'(cnt_r);
  assign capw  = CW'(out_capacity_r);
  assign cmaxw = CW'({COUNT_BITS{1'b1}});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      room[k] = (cntw + CW'(k + 1) < capw) && (cntw + CW'(k) < cmaxw);
    end
    na  = '0;
    ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < nc) begin
        if (room[k] && !ovf) na = na + 1'b1;
        else ovf = 1'b1;
      end
    end
    fin_ph  = ovf ? PH_ERR_OVF : mid_ph;
    cnt_new = cnt_r + COUNT_BITS'(na);
    if (fin_ph == PH_VALUE || fin_ph == PH_DONE) code = ffxd_pkg::ST_OK;
    else if (fin_ph == PH_ERR_OVF) code = ffxd_pkg::ST_OVERFLOW;
    else if (fin_ph == PH_ERR_NUL) code = ffxd_pkg::ST_NUL;
    else code = ffxd_pkg::ST_NOT_FOUND;
  end

  always_comb begin
    bq_data.data[0]     = cand[0];
    bq_data.data[1]     = cand[1];
    bq_data.data[2]     = cand[2];
    bq_data.has_status  = has_st;
    bq_data.code        = code;
    bq_data.count       = (code == ffxd_pkg::ST_OK) ?
                          ffxd_pkg::COUNT_OUT_BITS'(cnt_new) : '0;
    // With a status word the third data byte rides on the status word.
    if (has_st && na == 2'd3) begin
      bq_data.n_data      = 2'd2;
      bq_data.status_byte = (code == ffxd_pkg::ST_OK) ? cand[2] : '0;
    end else begin
      bq_data.n_data      = na;
      bq_data.status_byte = '0;
    end
    bq_push = accept && (has_st || na != '0);
  end

  always_comb begin
    ph_nxt  = ph_r;
    kp_nxt  = kp_r;
    pp_nxt  = pp_r;
    fh_nxt  = fh_r;
    cnt_nxt = cnt_r;
    if (ph_r == PH_IGNORE) begin
      if (final_byte) begin
        ph_nxt  = PH_KEY;
        kp_nxt  = '0;
        pp_nxt  = '0;
        fh_nxt  = '0;
        cnt_nxt = '0;
      end
    end else if (has_st) begin
      ph_nxt  = (text_byte == '0 && !final_byte) ? PH_IGNORE : PH_KEY;
      kp_nxt  = '0;
      pp_nxt  = '0;
      fh_nxt  = '0;
      cnt_nxt = '0;
    end else begin
      ph_nxt  = fin_ph;
      kp_nxt  = mid_kp;
      pp_nxt  = mid_pp;
      fh_nxt  = mid_fh;
      cnt_nxt = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_KEY;
      kp_r  <= '0;
      pp_r  <= '0;
      fh_r  <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      ph_r  <= ph_nxt;
      kp_r  <= kp_nxt;
      pp_r  <= pp_nxt;
      fh_r  <= fh_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/ffxd_back.sv -----
// Emitter: unpacks bundles into result words, one per cycle unless stalled.
module ffxd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ffxd_pkg::bundle_t   bq_data,
  input  logic                bq_empty,
  output logic                bq_pop,
  input  logic                oq_full,
  output logic                oq_push,
  output ffxd_pkg::result_t   oq_data
);

  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_idx;
  logic       last;

  assign last_idx = bq_data.n_data + 2'(bq_data.has_status) - 1'b1;
  assign last     = (idx_r == last_idx);
  assign oq_push  = !bq_empty && !oq_full;
  assign bq_pop   = oq_push && last;

  always_comb begin
    if (idx_r < bq_data.n_data) begin
      oq_data.kind     = ffxd_pkg::KIND_DATA;
      oq_data.out_byte = bq_data.data[idx_r];
      oq_data.code     = ffxd_pkg::ST_OK;
      oq_data.count    = '0;
      oq_data.run_end  = 1'b0;
    end else begin
      oq_data.kind     = ffxd_pkg::KIND_STATUS;
      oq_data.out_byte = bq_data.status_byte;
      oq_data.code     = bq_data.code;
      oq_data.count    = bq_data.count;
      oq_data.run_end  = 1'b1;
    end
    if (bq_pop) idx_nxt = '0;
    else if (oq_push) idx_nxt = idx_r + 1'b1;
    else idx_nxt = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- src/form_field_extract_decode.sv -----
// Top level of the form field extract and decode block.
// Takes one body byte per cycle while in_full is low and streams out the
// decoded value of the first field whose name equals the configured key,
// then one status word per body. The parser decodes each accepted byte
// and writes everything that byte produces (up to three words) into a
// four-entry bundle queue; the emitter drains that queue into a four-entry
// output queue at one word per cycle while that queue has room. Sustained
// input rate is one byte per cycle as long as bytes average no more than
// one result word and the output is popped. Each word passes through the
// bundle queue and then the output queue. Configure only while idle.
module form_field_extract_decode #(
  parameter int MAX_KEY_BYTES = 16,
  parameter int COUNT_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_item_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status_code,
  output logic [11:0] out_decoded_count,
  output logic        out_run_end
);

  localparam int BW = $bits(ffxd_pkg::bundle_t);
  localparam int RW = $bits(ffxd_pkg::result_t);

  logic              accept;
  logic              bq_push, bq_pop, bq_full, bq_empty;
  ffxd_pkg::bundle_t bq_wr, bq_rd;
  logic              oq_push, oq_full;
  ffxd_pkg::result_t oq_wr, oq_rd;

  assign in_full = bq_full;
  assign accept  = in_push && !bq_full;

  ffxd_front #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .bq_push    (bq_push),
    .bq_data    (bq_wr)
  );

  ffxd_fifo #(.WIDTH(BW), .AW(2)) u_bundle_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (bq_push),
    .wr_data (bq_wr),
    .pop     (bq_pop),
    .rd_data (bq_rd),
    .full    (bq_full),
    .empty   (bq_empty)
  );

  ffxd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bq_data  (bq_rd),
    .bq_empty (bq_empty),
    .bq_pop   (bq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_wr)
  );

  ffxd_fifo #(.WIDTH(RW), .AW(2)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_wr),
    .pop     (out_pop),
    .rd_data (oq_rd),
    .full    (oq_full),
    .empty   (out_empty)
  );

  assign out_item_kind     = oq_rd.kind;
  assign out_byte          = oq_rd.out_byte;
  assign out_status_code   = oq_rd.code;
  assign out_decoded_count = oq_rd.count;
  assign out_run_end       = oq_rd.run_end;

  // A decoded data byte is never zero, since %00 is rejected.
  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item_kind == ffxd_pkg::KIND_DATA) |-> (out_byte != 8'd0))
    else $error("data word carries a zero byte");

  // Only status words end a body, and they carry the end mark.
  a_run_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_run_end == (out_item_kind == ffxd_pkg::KIND_STATUS)))
    else $error("end mark does not match word kind");

  // Error and not-found status words carry no count and no trailing byte.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item_kind == ffxd_pkg::KIND_STATUS &&
     out_status_code != ffxd_pkg::ST_OK) |-> (out_decoded_count == '0 && out_byte == 8'd0))
    else $error("failed status word carries data");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
